// ===== hdl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape decoder package
// Shared types, constants and small lookup functions for the escape decoder.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_end;
  } out_t;

  // Everything one input item produces, handed from the front to the back.
  typedef struct packed {
    logic [CntW-1:0]              cnt;
    logic [MaxBytes-1:0][7:0]     bytes;
    logic                         str_end;
  } cmd_t;

  // Escape phase, one-hot.
  typedef enum logic [5:0] {
    PhNormal = 6'b000001,
    PhBslash = 6'b000010,
    PhU      = 6'b000100,
    PhD1     = 6'b001000,
    PhD2     = 6'b010000,
    PhD3     = 6'b100000
  } phase_e;

  // Returns {known, value} for the byte after a backslash.
  function automatic logic [8:0] esc_map(logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h5C:   r = {1'b1, 8'h5C};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h65:   r = {1'b1, 8'h1B};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h70:   r = {1'b1, 8'h70};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  // Returns {is_hex, value} for an ASCII hex digit in either case.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'b0_0000;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/escape_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder with \uXXXX to UTF-8
// Takes an escaped string one byte per item and delivers the unescaped bytes.
// ----------------------------------------------------------------------------
// The block accepts one input byte per clock cycle while the command queue
// has room and delivers one result byte per clock cycle while results are
// popped. A front stage tracks the escape state and turns each accepted item
// into a list of zero to six result bytes in the same cycle; that list goes
// into a command queue of CmdDepth entries. A back stage reads the oldest
// command and moves one byte per cycle into the result register while that
// register is free or popped, so an item that yields k bytes holds the back
// stage until all k are moved while the front keeps taking input until the
// command queue fills. With the queue and result register free, an accepted
// item's command is written into the queue, then its first byte into the
// result register. Items that only open or continue an escape yield nothing.
// The result port carries run_last on the final byte of each item and out_end
// on the final byte of the string. full and empty follow queue conventions:
// push is taken while full is low and pop is taken while empty is low.
module escape_unescape_utf8 #(
  parameter int unsigned CmdDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  esc_pkg::in_t  in_data_i,
  input  logic          pop,
  output logic          empty,
  output esc_pkg::out_t out_data_o
);

  logic          accept;
  logic          cmd_push;
  esc_pkg::cmd_t cmd_in;
  logic          cmd_full;
  logic          cmd_pop;
  logic          cmd_empty;
  esc_pkg::cmd_t cmd_head;

  // Input is held off whenever the command queue has no room.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  esc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  esc_cmdq #(
    .Depth (CmdDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  esc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (out_data_o)
  );

endmodule

// ===== hdl/esc_front.sv =====
// ----------------------------------------------------------------------------
// Escape decoder front
// Tracks the escape phase and turns each input item into a byte-list command.
// ----------------------------------------------------------------------------
module esc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  esc_pkg::in_t  in_i,
  output logic          cmd_push_o,
  output esc_pkg::cmd_t cmd_o
);

  esc_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q [3];
  logic [7:0]      held_d [3];
  logic [15:0]     code_q, code_d;
  logic            bad_q, bad_d;

  logic [7:0]      b;
  logic            last;
  logic [4:0]      hex;
  logic [8:0]      map;
  logic            bad_n;
  logic [15:0]     code_n;
  logic [esc_pkg::MaxBytes-1:0][7:0] lit;
  logic [esc_pkg::CntW-1:0] npend;
  logic [1:0]      hidx;
  esc_pkg::phase_e phase_nx;
  esc_pkg::cmd_t   cmd;

  assign b      = in_i.in_byte;
  assign last   = in_i.string_end;
  assign hex    = esc_pkg::hex_val(b);
  assign map    = esc_pkg::esc_map(b);
  assign bad_n  = bad_q | ~hex[4];
  assign code_n = hex[4] ? {code_q[11:0], hex[3:0]} : code_q;

  // Bytes held back by an unfinished escape, in output order.
  always_comb begin
    lit[0] = esc_pkg::ChBslash;
    lit[1] = esc_pkg::ChU;
    lit[2] = held_q[0];
    lit[3] = held_q[1];
    lit[4] = held_q[2];
    lit[5] = 8'h00;
  end

  always_comb begin
    case (phase_q)
      esc_pkg::PhU: begin
        npend = 3'd2; hidx = 2'd0; phase_nx = esc_pkg::PhD1;
      end
      esc_pkg::PhD1: begin
        npend = 3'd3; hidx = 2'd1; phase_nx = esc_pkg::PhD2;
      end
      esc_pkg::PhD2: begin
        npend = 3'd4; hidx = 2'd2; phase_nx = esc_pkg::PhD3;
      end
      esc_pkg::PhD3: begin
        npend = 3'd5; hidx = 2'd0; phase_nx = esc_pkg::PhNormal;
      end
      default: begin
        npend = 3'd1; hidx = 2'd0; phase_nx = esc_pkg::PhNormal;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.str_end = last;
    phase_d     = phase_q;
    held_d      = held_q;
    code_d      = code_q;
    bad_d       = bad_q;
    case (phase_q)
      esc_pkg::PhNormal: begin
        if (b == esc_pkg::ChBslash && !last) begin
          phase_d = esc_pkg::PhBslash;
        end else begin
          cmd.cnt      = 3'd1;
          cmd.bytes[0] = b;
        end
      end
      esc_pkg::PhBslash: begin
        phase_d = esc_pkg::PhNormal;
        if (b == esc_pkg::ChU) begin
          if (last) begin
            cmd.cnt      = 3'd2;
            cmd.bytes[0] = esc_pkg::ChBslash;
            cmd.bytes[1] = b;
          end else begin
            phase_d = esc_pkg::PhU;
            code_d  = '0;
            bad_d   = 1'b0;
          end
        end else if (map[8]) begin
          cmd.cnt      = 3'd1;
          cmd.bytes[0] = map[7:0];
        end else begin
          cmd.cnt      = 3'd2;
          cmd.bytes[0] = esc_pkg::ChBslash;
          cmd.bytes[1] = b;
        end
      end
      esc_pkg::PhU, esc_pkg::PhD1, esc_pkg::PhD2, esc_pkg::PhD3: begin
        code_d = code_n;
        bad_d  = bad_n;
        if (phase_q == esc_pkg::PhD3 && !bad_n) begin
          // All four digits were hex: encode the code point as UTF-8.
          phase_d = esc_pkg::PhNormal;
          if (code_n <= 16'h007F) begin
            cmd.cnt      = 3'd1;
            cmd.bytes[0] = code_n[7:0];
          end else if (code_n <= 16'h07FF) begin
            cmd.cnt      = 3'd2;
            cmd.bytes[0] = 8'hC0 | {3'b000, code_n[10:6]};
            cmd.bytes[1] = 8'h80 | {2'b00, code_n[5:0]};
          end else begin
            cmd.cnt      = 3'd3;
            cmd.bytes[0] = 8'hE0 | {4'b0000, code_n[15:12]};
            cmd.bytes[1] = 8'h80 | {2'b00, code_n[11:6]};
            cmd.bytes[2] = 8'h80 | {2'b00, code_n[5:0]};
          end
        end else if (phase_q == esc_pkg::PhD3 || last) begin
          // Bad digit or string ended early: give back everything literally.
          phase_d          = esc_pkg::PhNormal;
          cmd.bytes        = lit;
          cmd.bytes[npend] = b;
          cmd.cnt          = npend + 3'd1;
        end else begin
          held_d[hidx] = b;
          phase_d      = phase_nx;
        end
      end
      default: begin
        phase_d = esc_pkg::PhNormal;
      end
    endcase
    if (last) begin
      phase_d = esc_pkg::PhNormal;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept_i && (cmd.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= esc_pkg::PhNormal;
      code_q  <= '0;
      bad_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== hdl/esc_cmdq.sv =====
// ----------------------------------------------------------------------------
// Escape decoder command queue
// Small FIFO of commands between the front and the back.
// ----------------------------------------------------------------------------
module esc_cmdq #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  esc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output esc_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  esc_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/esc_back.sv =====
// ----------------------------------------------------------------------------
// Escape decoder back
// Walks the head command one byte per cycle into a free or popped result register.
// ----------------------------------------------------------------------------
module esc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  esc_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output esc_pkg::out_t res_o
);

  logic [esc_pkg::CntW-1:0] idx_q, idx_d;
  logic                     res_vld_q;
  esc_pkg::out_t            res_q, res_d;
  logic                     advance;
  logic                     is_last;

  assign advance   = !cmd_empty_i && (!res_vld_q || pop_i);
  assign is_last   = ((idx_q + 3'd1) == cmd_i.cnt);
  assign cmd_pop_o = advance && is_last;
  assign idx_d     = is_last ? '0 : idx_q + 3'd1;

  always_comb begin
    res_d.out_byte = cmd_i.bytes[idx_q];
    res_d.run_last = is_last;
    res_d.out_end  = is_last && cmd_i.str_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q     <= idx_d;
        res_vld_q <= 1'b1;
      end else if (pop_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign empty_o = !res_vld_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  // The byte index never runs past the head command's byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_empty_i |-> (idx_q < cmd_i.cnt))
    else $error("byte index beyond command length");

  // Between commands the index is parked at the first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_empty_i |-> (idx_q == '0))
    else $error("byte index not reset while queue empty");

  // The end-of-string byte is always the last byte of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.out_end) |-> res_q.run_last)
    else $error("end of string on a non-final result");

  // Retiring a command loads its final byte into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> res_vld_q && res_q.run_last)
    else $error("command retired without its final byte");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Escape decoder regression bench
// Drives escaped byte strings into the decoder through its queue-style ports,
// predicts the unescaped bytes with an independent model of the escape rules
// and checks every result item in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ItemTarget = 460;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 150;
  localparam int NoWant     = -1;   // row is checked against the predictor only

  // Escape phases of the predictor. The digit phases count digit bytes seen, hex or not.
  typedef enum int {
    ST_PLAIN,
    ST_BSLASH,
    ST_U,
    ST_D1,
    ST_D2,
    ST_D3
  } esc_state_e;

  // One row of the directed stimulus. When n_want is not NoWant, the row's
  // results are typed in: want holds the bytes in order, first byte at the top.
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        fin;
    int          n_want;
    logic [47:0] want;
  } dir_row_t;

  // The directed part opens with plain bytes at both extremes, then a known
  // escape, an unknown escape with a zero byte, a surrogate code point, a
  // \u escape with a non-hex digit, a \u escape cut short by the end of the
  // string, and finally a lone backslash that ends the string.
  localparam dir_row_t DirRows [25] = '{
    '{8'h41, 1'b0, 1,      48'h41_00_00_00_00_00},
    '{8'h00, 1'b0, 1,      48'h00_00_00_00_00_00},
    '{8'hFF, 1'b1, 1,      48'hFF_00_00_00_00_00},
    '{8'h5C, 1'b0, 0,      48'h0},
    '{8'h6E, 1'b0, 1,      48'h0A_00_00_00_00_00},
    '{8'h5C, 1'b0, 0,      48'h0},
    '{8'h00, 1'b0, 2,      48'h5C_00_00_00_00_00},
    '{8'h5C, 1'b0, 0,      48'h0},
    '{8'h75, 1'b0, 0,      48'h0},
    '{8'h44, 1'b0, 0,      48'h0},
    '{8'h38, 1'b0, 0,      48'h0},
    '{8'h30, 1'b0, 0,      48'h0},
    '{8'h30, 1'b0, NoWant, 48'h0},
    '{8'h5C, 1'b0, 0,      48'h0},
    '{8'h75, 1'b0, 0,      48'h0},
    '{8'h7A, 1'b0, 0,      48'h0},
    '{8'h31, 1'b0, 0,      48'h0},
    '{8'h32, 1'b0, 0,      48'h0},
    '{8'h33, 1'b0, 6,      48'h5C_75_7A_31_32_33},
    '{8'h5C, 1'b0, 0,      48'h0},
    '{8'h75, 1'b0, 0,      48'h0},
    '{8'h30, 1'b0, 0,      48'h0},
    '{8'h37, 1'b0, 0,      48'h0},
    '{8'h66, 1'b1, 5,      48'h5C_75_30_37_66_00},
    '{8'h5C, 1'b1, 1,      48'h5C_00_00_00_00_00}
  };

  // Bytes that form a known escape after a backslash.
  localparam logic [7:0] KnownEscChars [12] = '{
    8'h5C, 8'h27, 8'h22, 8'h61, 8'h62, 8'h65, 8'h66, 8'h6E, 8'h70, 8'h72, 8'h74, 8'h76
  };

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          push    = 1'b0;
  logic          pop     = 1'b0;
  logic          full;
  logic          empty;
  esc_pkg::in_t  in_item = '0;
  esc_pkg::out_t out_item;

  // Predictor state.
  esc_state_e  esc_state = ST_PLAIN;
  logic [7:0]  held_hex [3];
  logic [15:0] code_acc = '0;
  logic        hex_bad  = 1'b0;
  logic [7:0]  step_out [6];
  int          step_cnt;

  // Bytes the decoder still owes us, oldest first.
  esc_pkg::out_t unescaped_q [$];

  int          err_count    = 0;
  int          items_sent   = 0;
  int          results_seen = 0;
  int          cycle_count  = 0;
  bit          hold_done    = 1'b0;

  // Random sequence under construction.
  logic [7:0]  seq_bytes [8];
  logic        seq_fin   [8];
  int          seq_len;

  escape_unescape_utf8 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_item),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_item)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("escape_unescape_utf8 regression: fail");
      $finish;
    end
  end

  // Value of an ASCII hex digit, or 16 for any other byte.
  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return 16;
  endfunction

  // Control byte for a known escape; returns 0 when the byte is not one.
  function automatic bit escape_byte(logic [7:0] c, output logic [7:0] v);
    v = c;
    case (c)
      8'h5C, 8'h27, 8'h22, 8'h70: return 1'b1;  // these stand for themselves
      8'h61: v = 8'h07;
      8'h62: v = 8'h08;
      8'h65: v = 8'h1B;
      8'h66: v = 8'h0C;
      8'h6E: v = 8'h0A;
      8'h72: v = 8'h0D;
      8'h74: v = 8'h09;
      8'h76: v = 8'h0B;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void put_byte(logic [7:0] v);
    step_out[step_cnt] = v;
    step_cnt++;
  endfunction

  // An escape that does not complete comes out as it went in: the backslash,
  // the u if one was seen, and the hex digits collected so far.
  function automatic void put_pending();
    if (esc_state >= ST_BSLASH) put_byte(esc_pkg::ChBslash);
    if (esc_state >= ST_U) put_byte(esc_pkg::ChU);
    for (int k = 0; k < int'(esc_state) - int'(ST_U); k++) put_byte(held_hex[k]);
  endfunction

  // Advances the predictor by one input item and leaves the bytes it yields
  // in step_out[0 .. step_cnt-1].
  function automatic void unescape_step(esc_pkg::in_t item);
    logic [7:0] b;
    logic [7:0] mapped;
    logic       fin;
    int         h;
    b = item.in_byte;
    fin = item.string_end;
    step_cnt = 0;
    case (esc_state)
      ST_PLAIN: begin
        // A backslash on the final byte has nothing to escape.
        if (b == esc_pkg::ChBslash && !fin) esc_state = ST_BSLASH;
        else put_byte(b);
      end
      ST_BSLASH: begin
        if (b == esc_pkg::ChU) begin
          if (fin) begin
            put_pending();
            put_byte(b);
          end else begin
            esc_state = ST_U;
            code_acc = '0;
            hex_bad = 1'b0;
          end
        end else begin
          if (escape_byte(b, mapped)) begin
            put_byte(mapped);
          end else begin
            put_byte(esc_pkg::ChBslash);
            put_byte(b);
          end
          esc_state = ST_PLAIN;
        end
      end
      default: begin
        // Any byte counts as a digit here, a backslash too.
        h = hex_digit(b);
        if (h > 15) hex_bad = 1'b1;
        else code_acc = {code_acc[11:0], h[3:0]};
        if (esc_state == ST_D3) begin
          if (hex_bad) begin
            put_pending();
            put_byte(b);
          end else if (code_acc <= 16'h007F) begin
            put_byte(code_acc[7:0]);
          end else if (code_acc <= 16'h07FF) begin
            put_byte({3'b110, code_acc[10:6]});
            put_byte({2'b10, code_acc[5:0]});
          end else begin
            // Surrogates get no special treatment.
            put_byte({4'b1110, code_acc[15:12]});
            put_byte({2'b10, code_acc[11:6]});
            put_byte({2'b10, code_acc[5:0]});
          end
          esc_state = ST_PLAIN;
        end else if (fin) begin
          put_pending();
          put_byte(b);
        end else begin
          held_hex[int'(esc_state) - int'(ST_U)] = b;
          esc_state = esc_state_e'(int'(esc_state) + 1);
        end
      end
    endcase
    if (fin) esc_state = ST_PLAIN;
  endfunction

  // Queues what an accepted item must produce. Typed rows supply the bytes
  // themselves; the predictor still runs so that its state stays in step.
  function automatic void record_item(esc_pkg::in_t item, int n_want, logic [47:0] want);
    esc_pkg::out_t r;
    int            n;
    unescape_step(item);
    n = (n_want == NoWant) ? step_cnt : n_want;
    for (int k = 0; k < n; k++) begin
      r.out_byte = (n_want == NoWant) ? step_out[k] : want[47 - 8*k -: 8];
      r.run_last = (k == n - 1);
      r.out_end  = (k == n - 1) && item.string_end;
      unescaped_q.push_back(r);
    end
  endfunction

  function automatic void check_result(esc_pkg::out_t got);
    esc_pkg::out_t want;
    if (unescaped_q.size() == 0) begin
      $error("result with nothing expected: out_byte=%h run_last=%b out_end=%b",
             got.out_byte, got.run_last, got.out_end);
      err_count++;
      return;
    end
    want = unescaped_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
      err_count++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %b, got %b", want.run_last, got.run_last);
      err_count++;
    end
    if (got.out_end !== want.out_end) begin
      $error("out_end: expected %b, got %b", want.out_end, got.out_end);
      err_count++;
    end
  endfunction

  // Offers one item after a random gap and waits until the decoder takes it.
  // push stays high between back-to-back items, so it is never lowered and
  // raised again within one time step.
  task automatic send_item(esc_pkg::in_t item, int n_want, logic [47:0] want);
    int gap;
    gap = (((items_sent / 37) % 3) == 1) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= item;
    do @(posedge clk_i); while (full);
    record_item(item, n_want, want);
    items_sent++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h37 : 8'h57) + 8'(v);
  endfunction

  // Builds one random sequence. The largest share are hex escapes with random
  // code points, some with a spoiled digit; the rest are plain bytes, two-byte
  // escapes and noise made of escape fragments.
  task automatic make_sequence();
    int          kind;
    logic [15:0] cp;
    logic [7:0]  junk;
    int          pos;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      seq_len = 1;
      seq_bytes[0] = 8'($urandom_range(0, 255));
    end else if (kind < 35) begin
      seq_len = 2;
      seq_bytes[0] = esc_pkg::ChBslash;
      seq_bytes[1] = KnownEscChars[$urandom_range(0, 11)];
    end else if (kind < 45) begin
      seq_len = 2;
      seq_bytes[0] = esc_pkg::ChBslash;
      seq_bytes[1] = 8'($urandom_range(0, 255));
    end else if (kind < 88) begin
      case ($urandom_range(0, 5))
        0: cp = 16'($urandom_range(0, 'h7F));
        1: cp = 16'($urandom_range('h80, 'h7FF));
        2: cp = 16'($urandom_range('h800, 'hFFFF));
        3: cp = 16'($urandom_range('hD800, 'hDFFF));
        4: begin
          case ($urandom_range(0, 5))
            0: cp = 16'h0000;
            1: cp = 16'h007F;
            2: cp = 16'h0080;
            3: cp = 16'h07FF;
            4: cp = 16'h0800;
            default: cp = 16'hFFFF;
          endcase
        end
        default: cp = 16'($urandom);
      endcase
      seq_len = 6;
      seq_bytes[0] = esc_pkg::ChBslash;
      seq_bytes[1] = esc_pkg::ChU;
      for (int k = 0; k < 4; k++)
        seq_bytes[2 + k] = hex_char(cp[15 - 4*k -: 4], 1'($urandom_range(0, 1)));
      // Now and then spoil one digit so the escape passes through literally.
      if ($urandom_range(0, 6) == 0) begin
        do junk = 8'($urandom_range(0, 255)); while (hex_digit(junk) < 16);
        pos = $urandom_range(2, 5);
        seq_bytes[pos] = junk;
      end
    end else begin
      seq_len = $urandom_range(1, 6);
      for (int k = 0; k < seq_len; k++) begin
        case ($urandom_range(0, 3))
          0: seq_bytes[k] = esc_pkg::ChBslash;
          1: seq_bytes[k] = esc_pkg::ChU;
          2: seq_bytes[k] = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          default: seq_bytes[k] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    // String ends fall anywhere, often cutting an escape short.
    for (int k = 0; k < seq_len; k++) seq_fin[k] = ($urandom_range(0, 13) == 0);
  endtask

  // Result side: pops after a random gap, with some stretches of steady
  // popping, and once holds off long enough for the decoder to back up and
  // stall its input.
  initial begin : drain
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && results_seen >= 60) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      gap = (((results_seen / 41) % 3) == 1) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_result(out_item);
      results_seen++;
    end
  end

  initial begin : stimulus
    esc_pkg::in_t item;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[r]) begin
      item.in_byte = DirRows[r].in_byte;
      item.string_end = DirRows[r].fin;
      send_item(item, DirRows[r].n_want, DirRows[r].want);
    end

    while (items_sent < ItemTarget) begin
      make_sequence();
      for (int k = 0; k < seq_len; k++) begin
        item.in_byte = seq_bytes[k];
        item.string_end = seq_fin[k];
        send_item(item, NoWant, 48'h0);
      end
    end
    push <= 1'b0;

    // Let the last results drain, then watch a little longer for strays.
    while (unescaped_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (err_count == 0) begin
      $display("escape_unescape_utf8 regression: pass");
    end else begin
      $display("escape_unescape_utf8 regression: fail");
    end
    $finish;
  end

endmodule
